// ===== hw/rtl/vigenere_shift_cipher_top_assert.svh =====
// Assertion macros for the checker file vsc_checker.sv.
`ifndef VIGENERE_SHIFT_CIPHER_TOP_ASSERT_SVH
`define VIGENERE_SHIFT_CIPHER_TOP_ASSERT_SVH

// Checked only while out of reset.
`define VSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define VSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hw/rtl/vsc_pkg.sv =====
`default_nettype none

package vsc_pkg;

  localparam int unsigned MaxKeyPositions = 16;
  localparam int unsigned PosW            = $clog2(MaxKeyPositions);
  localparam int unsigned ShiftW          = 5;
  localparam int unsigned KeyLenW         = 5;
  localparam int unsigned KeyWordW        = 40;
  localparam int unsigned CfgDataW        = 40;
  localparam int unsigned CfgIdxW         = 2;

  localparam logic [5:0]         AlphabetSize   = 6'd26;
  localparam logic [7:0]         UpperBase      = 8'h41;
  localparam logic [7:0]         LowerBase      = 8'h61;
  localparam logic [KeyLenW-1:0] KeyLengthReset = 5'd13;

  typedef enum logic [CfgIdxW-1:0] {
    CfgKeyShiftsLow  = 2'd0,
    CfgKeyShiftsHigh = 2'd1,
    CfgKeyLength     = 2'd2,
    CfgCipherMode    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       end_of_text_out;
  } out_t;

  function automatic logic is_upper(logic [7:0] c);
    return (c >= UpperBase) && (c < UpperBase + 8'(AlphabetSize));
  endfunction

  function automatic logic is_lower(logic [7:0] c);
    return (c >= LowerBase) && (c < LowerBase + 8'(AlphabetSize));
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return is_upper(c) || is_lower(c);
  endfunction

  // Shift one byte by s (already below 26); non-letters pass through.
  function automatic logic [7:0] cipher_char(logic [7:0] c, logic [ShiftW-1:0] s,
                                             logic decrypt);
    logic [7:0] base;
    logic [4:0] off;
    logic [5:0] v;
    base = is_upper(c) ? UpperBase : LowerBase;
    off  = 5'(c - base);
    if (decrypt) begin
      v = {1'b0, off} + AlphabetSize - {1'b0, s};
    end else begin
      v = {1'b0, off} + {1'b0, s};
    end
    if (v >= AlphabetSize) begin
      v = v - AlphabetSize;
    end
    return is_letter(c) ? (base + {2'b00, v}) : c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/vigenere_shift_cipher_top.sv =====
// Vigenere shift cipher, one byte per beat.
// Input channel: in_valid_i / in_ready_o carry in_data_i (a byte and an end-of-text flag).
// Output channel: out_valid_o / out_ready_i carry out_data_o (the transformed byte and a
// copy of the flag). Letters move forward (encrypt) or back (decrypt) by the shift of the
// current key position, modulo 26, keeping case; other bytes pass unchanged.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i; always ready.
// Write only while no beat is in flight.
// A beat accepted at a clock edge is registered in the result register and shown on out_data_o after that edge.
// Throughput is one beat per cycle while the receiver takes results; the result register is the only stage.
// When the receiver stalls, the result holds and in_ready_o drops until it is taken;
// a beat is still accepted in the cycle the held result leaves.
// Reset clears the key position, the output valid, both shift words and the mode, and
// loads a key length of 13.
// The key position advances on every accepted beat, wraps at the key length and returns
// to zero after a beat that carries end-of-text.
`default_nettype none

module vigenere_shift_cipher_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output      logic                              in_ready_o,
  input  wire vsc_pkg::in_t                      in_data_i,
  output      logic                              out_valid_o,
  input  wire logic                              out_ready_i,
  output      vsc_pkg::out_t                     out_data_o,
  input  wire logic                              cfg_valid_i,
  output      logic                              cfg_ready_o,
  input  wire logic [vsc_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [vsc_pkg::CfgDataW-1:0]      cfg_data_i
);

  logic [vsc_pkg::KeyWordW-1:0] key_low_q, key_high_q;
  logic [vsc_pkg::KeyLenW-1:0]  key_len_q;
  logic                         mode_q;
  logic [vsc_pkg::PosW-1:0]     pos_q, pos_d;
  logic                         out_valid_q;
  vsc_pkg::out_t                out_data_q, out_data_d;

  logic [vsc_pkg::MaxKeyPositions-1:0][vsc_pkg::ShiftW-1:0] shifts;
  logic [vsc_pkg::ShiftW-1:0]   shift_raw, shift_red;
  logic [vsc_pkg::KeyLenW-1:0]  eff_len;
  logic [vsc_pkg::PosW:0]       pos_inc;
  logic                         in_fire;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;

  assign shifts    = {key_high_q, key_low_q};
  assign shift_raw = shifts[pos_q];
  assign shift_red = (shift_raw >= vsc_pkg::ShiftW'(vsc_pkg::AlphabetSize)) ?
                     shift_raw - vsc_pkg::ShiftW'(vsc_pkg::AlphabetSize) : shift_raw;

  always_comb begin
    if (key_len_q == '0) begin
      eff_len = vsc_pkg::KeyLenW'(1);
    end else if (key_len_q > vsc_pkg::KeyLenW'(vsc_pkg::MaxKeyPositions)) begin
      eff_len = vsc_pkg::KeyLenW'(vsc_pkg::MaxKeyPositions);
    end else begin
      eff_len = key_len_q;
    end
  end

  always_comb begin
    pos_inc = {1'b0, pos_q} + 1'b1;
    if (in_data_i.end_of_text || (vsc_pkg::KeyLenW'(pos_inc) >= eff_len)) begin
      pos_d = '0;
    end else begin
      pos_d = pos_inc[vsc_pkg::PosW-1:0];
    end
  end

  always_comb begin
    out_data_d.char_out        = vsc_pkg::cipher_char(in_data_i.char_in, shift_red, mode_q);
    out_data_d.end_of_text_out = in_data_i.end_of_text;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
      key_len_q  <= vsc_pkg::KeyLengthReset;
      mode_q     <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (vsc_pkg::cfg_idx_e'(cfg_index_i))
        vsc_pkg::CfgKeyShiftsLow:  key_low_q  <= cfg_data_i[vsc_pkg::KeyWordW-1:0];
        vsc_pkg::CfgKeyShiftsHigh: key_high_q <= cfg_data_i[vsc_pkg::KeyWordW-1:0];
        vsc_pkg::CfgKeyLength:     key_len_q  <= cfg_data_i[vsc_pkg::KeyLenW-1:0];
        vsc_pkg::CfgCipherMode:    mode_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        pos_q       <= pos_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload needs no reset; load only on an accepted beat.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/vsc_checker.sv =====
`default_nettype none

`include "vigenere_shift_cipher_top_assert.svh"

module vsc_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_ready_o,
  input wire vsc_pkg::in_t  in_data_i,
  input wire logic          out_valid_o,
  input wire logic          out_ready_i,
  input wire vsc_pkg::out_t out_data_o
);

  logic       in_fire;
  logic       in_letter;
  logic       in_eot, out_eot;
  logic [7:0] in_char, out_char;

  assign in_fire   = in_valid_i && in_ready_o;
  assign in_letter = vsc_pkg::is_letter(in_data_i.char_in);
  assign in_eot    = in_data_i.end_of_text;
  assign out_eot   = out_data_o.end_of_text_out;
  assign in_char   = in_data_i.char_in;
  assign out_char  = out_data_o.char_out;

  `VSC_ASSERT_ALWAYS(a_no_valid_in_reset, !rst_ni |-> !out_valid_o, "out valid during reset")

  `VSC_ASSERT(a_fire_gives_result, in_fire |=> out_valid_o, "accepted beat gave no result")

  // Free or draining output register must take a new beat.
  `VSC_ASSERT(a_free_takes_beat, (!out_valid_o || out_ready_i) |-> in_ready_o, "not ready")

  `VSC_ASSERT(a_eot_copied, in_fire |=> (out_eot == $past(in_eot)), "end flag not copied")

  `VSC_ASSERT(a_non_letter, (in_fire && !in_letter) |=> (out_char == $past(in_char)), "byte changed")

endmodule

bind vigenere_shift_cipher_top vsc_checker u_vsc_checker (.*);

`default_nettype wire

// ===== tb/vigenere_shift_cipher_top_tb.sv =====
`default_nettype none

module vigenere_shift_cipher_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vsc_pkg::*;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b1;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  in_t                 in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_t                out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  // Shadow copy of the cipher state and key registers
  logic [KeyWordW-1:0] shifts_lo = '0;
  logic [KeyWordW-1:0] shifts_hi = '0;
  logic [KeyLenW-1:0]  key_len   = KeyLengthReset;
  logic                decrypt   = 1'b0;
  logic [PosW-1:0]     key_pos   = '0;

  out_t        pending_chars[$];
  int unsigned mismatch_count = 0;
  int unsigned gap_pct        = 0;
  int unsigned stall_pct      = 0;
  int unsigned hold_left      = 0;

  vigenere_shift_cipher_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Work out the ciphered byte for one beat and advance the key position.
  function automatic out_t encode_char(in_t d);
    out_t                r;
    logic [KeyWordW-1:0] word;
    logic [ShiftW-1:0]   s;
    logic [7:0]          base;
    logic                letter;
    int unsigned         v;
    int unsigned         len;
    int unsigned         nxt;
    r.char_out        = d.char_in;
    r.end_of_text_out = d.end_of_text;
    word = key_pos[3] ? shifts_hi : shifts_lo;
    s    = word[key_pos[2:0]*ShiftW +: ShiftW];
    if (s >= AlphabetSize) begin
      s = s - ShiftW'(AlphabetSize);
    end
    letter = 1'b1;
    base   = UpperBase;
    if (d.char_in >= UpperBase && d.char_in < UpperBase + 8'd26) begin
      base = UpperBase;
    end else if (d.char_in >= LowerBase && d.char_in < LowerBase + 8'd26) begin
      base = LowerBase;
    end else begin
      letter = 1'b0;
    end
    if (letter) begin
      v = d.char_in - base;
      v = decrypt ? v + 26 - s : v + s;
      if (v >= 26) begin
        v = v - 26;
      end
      r.char_out = base + 8'(v);
    end
    len = (key_len == 0) ? 1 : (key_len > MaxKeyPositions) ? MaxKeyPositions : key_len;
    nxt = key_pos + 1;
    if (d.end_of_text) begin
      key_pos = '0;
    end else begin
      key_pos = (nxt >= len) ? '0 : PosW'(nxt);
    end
    return r;
  endfunction

  function automatic logic [39:0] rand40();
    return {8'($urandom_range(255)), 32'($urandom)};
  endfunction

  function automatic logic [7:0] pick_char(int unsigned noise);
    if ($urandom_range(99) < noise) begin
      return 8'($urandom_range(255));
    end
    return ($urandom_range(1) ? UpperBase : LowerBase) + 8'($urandom_range(25));
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgKeyShiftsLow:  shifts_lo = val;
      CfgKeyShiftsHigh: shifts_hi = val;
      CfgKeyLength:     key_len   = val[KeyLenW-1:0];
      CfgCipherMode:    decrypt   = val[0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_char(input logic [7:0] c, input logic eot);
    in_t d;
    d.char_in     = c;
    d.end_of_text = eot;
    if ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    do @(posedge clk_i); while (!in_ready_o);
    pending_chars.push_back(encode_char(d));
  endtask

  // Drop valid and hold until every result has drained.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_chars.size() != 0);
    @(posedge clk_i);
  endtask

  task automatic test_char_extremes();
    write_reg(CfgKeyShiftsLow,
              {5'd7, 5'd24, 5'd13, 5'd1, 5'd31, 5'd26, 5'd25, 5'd0});
    write_reg(CfgKeyShiftsHigh,
              {5'd31, 5'd30, 5'd29, 5'd28, 5'd27, 5'd26, 5'd12, 5'd3});
    write_reg(CfgKeyLength, 40'd16);
    write_reg(CfgCipherMode, 40'd0);
    send_char("A", 1'b0);
    send_char("Z", 1'b0);
    send_char("a", 1'b0);
    send_char("z", 1'b0);
    send_char(8'h40, 1'b0);
    send_char(8'h5B, 1'b0);
    send_char(8'h60, 1'b0);
    send_char(8'h7B, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
    drain();
  endtask

  task automatic test_decrypt();
    write_reg(CfgCipherMode, 40'd1);
    send_char("A", 1'b0);
    send_char("z", 1'b0);
    send_char("M", 1'b0);
    send_char("b", 1'b1);
    drain();
  endtask

  task automatic test_key_length_limits();
    // zero acts as one, anything past sixteen saturates
    write_reg(CfgKeyLength, 40'd0);
    send_char("q", 1'b0);
    send_char("Q", 1'b0);
    drain();
    write_reg(CfgKeyLength, 40'd31);
    send_char("k", 1'b0);
    send_char("K", 1'b1);
    drain();
  endtask

  task automatic test_position_beyond_length();
    write_reg(CfgKeyLength, 40'd16);
    write_reg(CfgCipherMode, 40'd0);
    for (int i = 0; i < 5; i++) begin
      send_char("a" + 8'(i), 1'b0);
    end
    drain();
    // position now sits past the new length: its shift is used, then wrap
    write_reg(CfgKeyLength, 40'd2);
    send_char("m", 1'b0);
    send_char("N", 1'b0);
    drain();
  endtask

  task automatic test_random_phase(input int unsigned n, input int unsigned gap,
                                   input int unsigned stall, input logic [4:0] len,
                                   input logic mode);
    logic [39:0] val;
    int unsigned sent;
    int unsigned run;
    logic        broken;
    write_reg(CfgKeyShiftsLow, rand40());
    write_reg(CfgKeyShiftsHigh, rand40());
    val      = rand40();
    val[4:0] = len;
    write_reg(CfgKeyLength, val);
    val      = rand40();
    val[0]   = mode;
    write_reg(CfgCipherMode, val);
    gap_pct   = gap;
    stall_pct = stall;
    sent      = 0;
    while (sent < n) begin
      broken = ($urandom_range(99) < 15);
      run    = $urandom_range(40, 1);
      for (int i = 0; i < run; i++) begin
        if (broken) begin
          send_char(pick_char(100), 1'($urandom_range(1)));
        end else begin
          send_char(pick_char(20), i == run - 1);
        end
      end
      sent += run;
    end
    drain();
    gap_pct   = 0;
    stall_pct = 0;
  endtask

  task automatic test_backpressure();
    gap_pct   = 0;
    stall_pct = 0;
    hold_left = 40;
    for (int i = 0; i < 20; i++) begin
      send_char(pick_char(10), i == 19);
    end
    drain();
  endtask

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected beat char_out=%02h end_of_text_out=%0b",
                 $time, out_data_o.char_out, out_data_o.end_of_text_out);
        mismatch_count++;
      end else begin
        want = pending_chars.pop_front();
        if (out_data_o.char_out !== want.char_out) begin
          $display("%0t: char_out expected %02h got %02h",
                   $time, want.char_out, out_data_o.char_out);
          mismatch_count++;
        end
        if (out_data_o.end_of_text_out !== want.end_of_text_out) begin
          $display("%0t: end_of_text_out expected %0b got %0b",
                   $time, want.end_of_text_out, out_data_o.end_of_text_out);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_char_extremes();
    test_decrypt();
    test_key_length_limits();
    test_position_beyond_length();
    test_random_phase(290, 0, 0, 5'd16, 1'b0);
    test_random_phase(290, 56, 0, 5'd1, 1'b1);
    test_backpressure();
    test_random_phase(290, 0, 56, 5'($urandom_range(31)), 1'b0);
    test_random_phase(290, 35, 35, 5'($urandom_range(15, 2)), 1'b1);
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0 && pending_chars.size() == 0) begin
      $display("vigenere_shift_cipher_top_tb OK");
    end else begin
      $display("vigenere_shift_cipher_top_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("vigenere_shift_cipher_top_tb NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
